/* rtl/ppr_pkg.sv */
// Package for the priority packet router: payload structs, event codes, constants.
// Used by the top level, the front part and the back part; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ppr_pkg;

  localparam int unsigned DefaultQueueDepth = 1024;
  localparam logic [31:0] RejectLimit = 32'd10;
  localparam int unsigned NumFifos = 3;
  localparam int unsigned NumCfgRegs = 8;

  // Request kinds.
  localparam logic [2:0] REQ_ARRIVE  = 3'd0;
  localparam logic [2:0] REQ_FORWARD = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_RESET   = 3'd3;
  localparam logic [2:0] REQ_STATS   = 3'd4;

  // Event codes.
  localparam logic [3:0] EV_QUEUED    = 4'd0;
  localparam logic [3:0] EV_REJECTED  = 4'd1;
  localparam logic [3:0] EV_FULL      = 4'd2;
  localparam logic [3:0] EV_UNKNOWN   = 4'd3;
  localparam logic [3:0] EV_DELIVERED = 4'd4;
  localparam logic [3:0] EV_IDLE      = 4'd5;
  localparam logic [3:0] EV_BAD_DST   = 4'd6;
  localparam logic [3:0] EV_STOPPED   = 4'd7;
  localparam logic [3:0] EV_CHECKED   = 4'd8;
  localparam logic [3:0] EV_RESET     = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] CFG_REJ_A  = 3'd0;
  localparam logic [2:0] CFG_PORT1  = 3'd4;
  localparam logic [2:0] CFG_PORT2  = 3'd5;
  localparam logic [2:0] CFG_PORT3  = 3'd6;
  localparam logic [2:0] CFG_BCAST  = 3'd7;

  localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [1:0]  pkt_class;
    logic [31:0] tag_word;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [1:0]  port_id;
    logic [31:0] out_src;
    logic [31:0] out_dst;
    logic [1:0]  out_class;
    logic [31:0] out_tag;
    logic        last_result;
    logic [31:0] created_total;
    logic [31:0] queued_total;
    logic [31:0] rejected_total;
    logic        is_running;
  } out_item_t;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [1:0]  pkt_class;
    logic [31:0] tag_word;
    logic        src_rejected;
  } cmd_t;

  function automatic logic in_window(input logic [63:0] w, input logic [31:0] a);
    in_window = (w[63:32] <= a) && (a <= w[31:0]);
  endfunction

endpackage
`default_nettype wire

/* rtl/priority_packet_router_core.sv */
// Top level of the strict-priority packet router: configuration registers,
// front and back parts. Depends on ppr_pkg, ppr_front, ppr_back, ppr_ram.
//
// Items enter through a push/full queue port and results leave through an
// empty/pop queue port. An accepted item waits in the front queue, and the back
// part registers its result; a forward of a queued packet goes through a read
// state for the registered read of the shared packet store and then an emit
// state that sends each broadcast copy in turn. A result that is not
// popped holds the back part, and the two-entry queue in front of it then
// fills and raises full. Request codes five to seven are discarded at the
// input and give no result.
`timescale 1ns / 1ps
`default_nettype none
module priority_packet_router_core
  import ppr_pkg::*;
#(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] cfg [NumCfgRegs];
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCfgRegs; i++) begin
        cfg[i] <= '0;
      end
    end else if (cfg_valid) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  ppr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .rej_a     (cfg[CFG_REJ_A]),
    .rej_b     (cfg[CFG_REJ_A + 3'd1]),
    .rej_c     (cfg[CFG_REJ_A + 3'd2]),
    .rej_d     (cfg[CFG_REJ_A + 3'd3]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ppr_back #(.QueueDepth(QueueDepth)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .port1_win (cfg[CFG_PORT1]),
    .port2_win (cfg[CFG_PORT2]),
    .port3_win (cfg[CFG_PORT3]),
    .bcast_win (cfg[CFG_BCAST]),
    .empty     (empty),
    .pop       (pop),
    .res       (out_item)
  );

endmodule
`default_nettype wire

/* rtl/ppr_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ppr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/ppr_front.sv */
// Front part: accepts items, drops unused request codes, checks source windows.
// Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppr_front
  import ppr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  input  wire logic [63:0] rej_a,
  input  wire logic [63:0] rej_b,
  input  wire logic [63:0] rej_c,
  input  wire logic [63:0] rej_d,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_pop
);

  // Two-entry queue between the front and back parts.
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign take      = push && !full && (in_item.req_type <= REQ_STATS);
  assign do_pop    = cmd_pop && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // Queue write with source classification.
  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr].req_type     <= in_item.req_type;
      q[wr_ptr].src_addr     <= in_item.src_addr;
      q[wr_ptr].dst_addr     <= in_item.dst_addr;
      q[wr_ptr].pkt_class    <= in_item.pkt_class;
      q[wr_ptr].tag_word     <= in_item.tag_word;
      q[wr_ptr].src_rejected <= in_window(rej_a, in_item.src_addr) ||
                                in_window(rej_b, in_item.src_addr) ||
                                in_window(rej_c, in_item.src_addr) ||
                                in_window(rej_d, in_item.src_addr);
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, take} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* rtl/ppr_back.sv */
// Back part: priority FIFOs, counters, forwarding and the result register.
// Depends on ppr_pkg and ppr_ram.
`timescale 1ns / 1ps
`default_nettype none
module ppr_back
  import ppr_pkg::*;
#(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic [63:0] port1_win,
  input  wire logic [63:0] port2_win,
  input  wire logic [63:0] port3_win,
  input  wire logic [63:0] bcast_win,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        res
);

  localparam int unsigned PtrW  = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW = $clog2(NumFifos * QueueDepth);
  localparam logic [FillW-1:0] FullFill = FillW'(QueueDepth);
  localparam logic [PtrW-1:0]  LastPtr  = PtrW'(QueueDepth - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [PtrW-1:0]  head [NumFifos];
  logic [FillW-1:0] fill [NumFifos];
  logic [31:0]      created;
  logic [31:0]      queued;
  logic [31:0]      rejected;
  logic             running;
  logic [1:0]       sel_q;
  logic [1:0]       copy_port;
  logic             res_valid;
  logic             res_free;
  logic             mem_we;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [PtrW-1:0]  tail;
  logic [PtrW:0]    tail_sum;
  logic [95:0]      rd_data;
  logic [95:0]      pkt_data;
  logic             bcast_only;
  logic [1:0]       cls;
  logic [1:0]       first_q;
  logic             any_full;

  assign empty    = !res_valid;
  assign res_free = !res_valid || pop;
  assign cls      = cmd.pkt_class;

  // Set when the held packet goes out as three broadcast copies (broadcast window only).
  assign bcast_only = !in_window(port1_win, pkt_data[63:32]) &&
                      !in_window(port2_win, pkt_data[63:32]) &&
                      !in_window(port3_win, pkt_data[63:32]) &&
                      in_window(bcast_win, pkt_data[63:32]);

  // First non-empty FIFO, highest priority first.
  always_comb begin
    if (fill[0] != '0) begin
      first_q = 2'd0;
    end else if (fill[1] != '0) begin
      first_q = 2'd1;
    end else if (fill[2] != '0) begin
      first_q = 2'd2;
    end else begin
      first_q = CLASS_UNKNOWN;
    end
  end

  // Write position of the arriving packet.
  always_comb begin
    any_full = 1'b0;
    tail     = '0;
    tail_sum = '0;
    if (cls != CLASS_UNKNOWN) begin
      any_full = (fill[cls] >= FullFill);
      tail_sum = {1'b0, head[cls]} + (PtrW + 1)'(fill[cls]);
      if (tail_sum >= (PtrW + 1)'(QueueDepth)) begin
        tail_sum = tail_sum - (PtrW + 1)'(QueueDepth);
      end
      tail = tail_sum[PtrW-1:0];
    end
  end

  assign mem_we  = (state == ST_IDLE) && cmd_valid && res_free && running &&
                   (cmd.req_type == REQ_ARRIVE) && !cmd.src_rejected &&
                   (cls != CLASS_UNKNOWN) && !any_full;
  assign wr_addr = AddrW'(cls) * AddrW'(QueueDepth) + AddrW'(tail);
  assign rd_addr = AddrW'(first_q) * AddrW'(QueueDepth) +
                   AddrW'(head[first_q == CLASS_UNKNOWN ? 2'd0 : first_q]);

  ppr_ram #(.Width(96), .Depth(NumFifos * QueueDepth)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data ({cmd.src_addr, cmd.dst_addr, cmd.tag_word}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && res_free) begin
          if (cmd.req_type == REQ_FORWARD && running && first_q != CLASS_UNKNOWN) begin
            state_next = ST_READ;
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        // Leave with the last result of the forward.
        if (res_free && ((copy_port == 2'd0 && !bcast_only) ||
                         copy_port == 2'd2 || copy_port == 2'd3)) begin
          state_next = ST_IDLE;
          cmd_pop    = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer, FIFO bookkeeping, counters and result register.
  always_ff @(posedge clk) begin
    logic [31:0] d;
    d = pkt_data[63:32];
    if (rst) begin
      state     <= ST_IDLE;
      created   <= '0;
      queued    <= '0;
      rejected  <= '0;
      running   <= 1'b1;
      res_valid <= 1'b0;
      copy_port <= 2'd0;
      sel_q     <= 2'd0;
      for (int i = 0; i < NumFifos; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && res_free) begin
            res       <= '0;
            res.last_result <= 1'b1;
            res.created_total  <= created;
            res.queued_total   <= queued;
            res.rejected_total <= rejected;
            res.is_running     <= running;
            res_valid <= 1'b1;
            case (cmd.req_type)
              REQ_ARRIVE: begin
                if (!running) begin
                  res.event_code <= EV_STOPPED;
                end else begin
                  created <= created + 32'd1;
                  res.created_total <= created + 32'd1;
                  if (cmd.src_rejected) begin
                    res.event_code <= EV_REJECTED;
                    if (rejected != '1) begin
                      rejected <= rejected + 32'd1;
                      res.rejected_total <= rejected + 32'd1;
                    end
                  end else if (cls == CLASS_UNKNOWN) begin
                    res.event_code <= EV_UNKNOWN;
                  end else if (any_full) begin
                    res.event_code <= EV_FULL;
                  end else begin
                    res.event_code <= EV_QUEUED;
                    fill[cls] <= fill[cls] + FillW'(1);
                    queued <= queued + 32'd1;
                    res.queued_total <= queued + 32'd1;
                  end
                end
              end
              REQ_FORWARD: begin
                if (!running) begin
                  res.event_code <= EV_STOPPED;
                end else if (first_q == CLASS_UNKNOWN) begin
                  res.event_code <= EV_IDLE;
                end else begin
                  res_valid <= 1'b0;
                  sel_q     <= first_q;
                  fill[first_q] <= fill[first_q] - FillW'(1);
                  head[first_q] <= (head[first_q] == LastPtr) ? '0 :
                                   head[first_q] + PtrW'(1);
                end
              end
              REQ_STOP: begin
                if (rejected >= RejectLimit) begin
                  running <= 1'b0;
                  res.is_running <= 1'b0;
                  res.event_code <= EV_STOPPED;
                end else begin
                  res.event_code <= running ? EV_CHECKED : EV_STOPPED;
                end
              end
              REQ_RESET: begin
                rejected <= '0;
                running  <= 1'b1;
                res.rejected_total <= '0;
                res.is_running     <= 1'b1;
                res.event_code     <= EV_RESET;
              end
              default: res.event_code <= EV_CHECKED;
            endcase
          end
        end
        ST_READ: begin
          // Hold the popped packet while its results go out.
          copy_port <= 2'd0;
          pkt_data  <= rd_data;
        end
        ST_EMIT: begin
          if (res_free && copy_port != 2'd3 &&
              !(copy_port != 2'd0 && res.port_id == 2'd0)) begin
            res.created_total  <= created;
            res.queued_total   <= queued;
            res.rejected_total <= rejected;
            res.is_running     <= running;
            res.last_result    <= 1'b1;
            res_valid          <= 1'b1;
            res.out_src   <= pkt_data[95:64];
            res.out_dst   <= d;
            res.out_tag   <= pkt_data[31:0];
            res.out_class <= sel_q;
            res.event_code <= EV_DELIVERED;
            copy_port <= 2'd3;
            if (copy_port != 2'd0) begin
              // Next broadcast copy.
              res.port_id <= copy_port + 2'd1;
              res.last_result <= (copy_port == 2'd2);
              copy_port <= (copy_port == 2'd2) ? 2'd3 : copy_port + 2'd1;
            end else if (in_window(port1_win, d)) begin
              res.port_id <= 2'd1;
            end else if (in_window(port2_win, d)) begin
              res.port_id <= 2'd2;
            end else if (in_window(port3_win, d)) begin
              res.port_id <= 2'd3;
            end else if (in_window(bcast_win, d)) begin
              res.port_id <= 2'd1;
              res.last_result <= 1'b0;
              copy_port <= 2'd1;
            end else begin
              res.port_id <= 2'd0;
              res.out_src <= '0;
              res.out_dst <= '0;
              res.out_tag <= '0;
              res.out_class <= 2'd0;
              res.event_code <= EV_BAD_DST;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* test/tb_priority_packet_router_core.sv */
// Self-checking testbench for priority_packet_router_core: directed and random items,
// predicted in the bench and compared field by field. Depends on ppr_pkg and the RTL.
`timescale 1ns / 1ps
module tb_priority_packet_router_core;
  import ppr_pkg::*;

  localparam logic [2:0] CFG_REJ_B = CFG_REJ_A + 3'd1;
  localparam logic [2:0] CFG_REJ_C = CFG_REJ_A + 3'd2;
  localparam logic [2:0] CFG_REJ_D = CFG_REJ_A + 3'd3;
  localparam logic [63:0] WIN_ALL   = {32'h0, 32'hFFFF_FFFF};
  localparam logic [63:0] WIN_NONE  = {32'hFFFF_FFFF, 32'h0};
  localparam int unsigned Depth     = DefaultQueueDepth;
  localparam int unsigned HoldOff   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  priority_packet_router_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted router state.
  logic [63:0] win_reg [8];
  logic [31:0] pkt_src [NumFifos][Depth];
  logic [31:0] pkt_dst [NumFifos][Depth];
  logic [31:0] pkt_tag [NumFifos][Depth];
  int unsigned q_head [NumFifos];
  int unsigned q_fill [NumFifos];
  logic [31:0] n_created = '0;
  logic [31:0] n_queued = '0;
  logic [31:0] n_rejected = '0;
  logic running = 1'b1;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int cfg_writes = 0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit idling = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;

  function automatic bit hits(logic [63:0] w, logic [31:0] a);
    return (w[63:32] <= a) && (a <= w[31:0]);
  endfunction

  function automatic out_item_t router_result(logic [3:0] ev, logic [1:0] port,
                                              logic [31:0] s, logic [31:0] d,
                                              logic [1:0] cls, logic [31:0] tag);
    out_item_t r;
    r = '0;
    r.event_code = ev;
    r.port_id = port;
    r.out_src = s;
    r.out_dst = d;
    r.out_class = cls;
    r.out_tag = tag;
    r.created_total = n_created;
    r.queued_total = n_queued;
    r.rejected_total = n_rejected;
    r.is_running = running;
    return r;
  endfunction

  // Updates the predicted state for one item and queues its results.
  function automatic void route_item(in_item_t it);
    out_item_t res[$];
    int q;
    int unsigned pos;
    logic [31:0] s, d, t;
    if (it.req_type > REQ_STATS) return;
    if ((it.req_type == REQ_ARRIVE || it.req_type == REQ_FORWARD) && !running) begin
      res.push_back(router_result(EV_STOPPED, 0, 0, 0, 0, 0));
    end else if (it.req_type == REQ_ARRIVE) begin
      n_created = n_created + 1;
      if (hits(win_reg[CFG_REJ_A], it.src_addr) || hits(win_reg[CFG_REJ_B], it.src_addr) ||
          hits(win_reg[CFG_REJ_C], it.src_addr) || hits(win_reg[CFG_REJ_D], it.src_addr)) begin
        if (n_rejected != 32'hFFFF_FFFF) n_rejected = n_rejected + 1;
        res.push_back(router_result(EV_REJECTED, 0, 0, 0, 0, 0));
      end else if (it.pkt_class == CLASS_UNKNOWN) begin
        res.push_back(router_result(EV_UNKNOWN, 0, 0, 0, 0, 0));
      end else if (q_fill[it.pkt_class] >= Depth) begin
        res.push_back(router_result(EV_FULL, 0, 0, 0, 0, 0));
      end else begin
        q = it.pkt_class;
        pos = (q_head[q] + q_fill[q]) % Depth;
        pkt_src[q][pos] = it.src_addr;
        pkt_dst[q][pos] = it.dst_addr;
        pkt_tag[q][pos] = it.tag_word;
        q_fill[q]++;
        n_queued = n_queued + 1;
        res.push_back(router_result(EV_QUEUED, 0, 0, 0, 0, 0));
      end
    end else if (it.req_type == REQ_FORWARD) begin
      q = 0;
      while (q < NumFifos && q_fill[q] == 0) q++;
      if (q >= NumFifos) begin
        res.push_back(router_result(EV_IDLE, 0, 0, 0, 0, 0));
      end else begin
        s = pkt_src[q][q_head[q]];
        d = pkt_dst[q][q_head[q]];
        t = pkt_tag[q][q_head[q]];
        q_head[q] = (q_head[q] + 1) % Depth;
        q_fill[q]--;
        if (hits(win_reg[CFG_PORT1], d)) begin
          res.push_back(router_result(EV_DELIVERED, 2'd1, s, d, 2'(q), t));
        end else if (hits(win_reg[CFG_PORT2], d)) begin
          res.push_back(router_result(EV_DELIVERED, 2'd2, s, d, 2'(q), t));
        end else if (hits(win_reg[CFG_PORT3], d)) begin
          res.push_back(router_result(EV_DELIVERED, 2'd3, s, d, 2'(q), t));
        end else if (hits(win_reg[CFG_BCAST], d)) begin
          for (int p = 1; p <= 3; p++)
            res.push_back(router_result(EV_DELIVERED, 2'(p), s, d, 2'(q), t));
        end else begin
          res.push_back(router_result(EV_BAD_DST, 0, 0, 0, 0, 0));
        end
      end
    end else if (it.req_type == REQ_STOP) begin
      if (n_rejected >= RejectLimit) running = 1'b0;
      res.push_back(router_result(running ? EV_CHECKED : EV_STOPPED, 0, 0, 0, 0, 0));
    end else if (it.req_type == REQ_RESET) begin
      n_rejected = '0;
      running = 1'b1;
      res.push_back(router_result(EV_RESET, 0, 0, 0, 0, 0));
    end else begin
      res.push_back(router_result(EV_CHECKED, 0, 0, 0, 0, 0));
    end
    res[res.size() - 1].last_result = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: handshakes, prediction at input, comparison at output.
  always @(posedge clk) begin
    out_item_t want;
    in_took <= !rst && push && !full;
    out_took <= !rst && pop && !empty;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        win_reg[cfg_index] = cfg_data;
        cfg_writes++;
      end
      if (push && !full) route_item(in_item);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, expected none actual %p", $time, out_item);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("event_code", want.event_code, out_item.event_code);
          check_field("port_id", want.port_id, out_item.port_id);
          check_field("out_src", want.out_src, out_item.out_src);
          check_field("out_dst", want.out_dst, out_item.out_dst);
          check_field("out_class", want.out_class, out_item.out_class);
          check_field("out_tag", want.out_tag, out_item.out_tag);
          check_field("last_result", want.last_result, out_item.last_result);
          check_field("created_total", want.created_total, out_item.created_total);
          check_field("queued_total", want.queued_total, out_item.queued_total);
          check_field("rejected_total", want.rejected_total, out_item.rejected_total);
          check_field("is_running", want.is_running, out_item.is_running);
        end
      end
    end
  end

  // Sender: offers pending items with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && !in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        push <= 1'b1;
        send_gap = idling ? $urandom_range(0, 11) : 0;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per item, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldOff;
      end
      if (out_took) recv_gap = idling ? $urandom_range(0, 11) : 0;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_item(logic [2:0] req, logic [31:0] src, logic [31:0] dst,
                                         logic [1:0] cls, logic [31:0] tag);
    in_item_t it;
    it.req_type = req;
    it.src_addr = src;
    it.dst_addr = dst;
    it.pkt_class = cls;
    it.tag_word = tag;
    return it;
  endfunction

  // Picks an address near the edges of a window, or anywhere.
  function automatic logic [31:0] near_window(logic [63:0] w);
    case ($urandom_range(0, 4))
      0: return w[63:32];
      1: return w[31:0];
      2: return w[63:32] - 1;
      3: return w[31:0] + 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_item();
    int pick;
    logic [2:0] req;
    logic [1:0] cls;
    pick = $urandom_range(0, 99);
    if (pick < 45) req = REQ_ARRIVE;
    else if (pick < 80) req = REQ_FORWARD;
    else if (pick < 86) req = REQ_STOP;
    else if (pick < 91) req = REQ_RESET;
    else if (pick < 96) req = REQ_STATS;
    else req = 3'($urandom_range(5, 7));
    cls = ($urandom_range(0, 9) == 0) ? CLASS_UNKNOWN : 2'($urandom_range(0, 2));
    return make_item(req, near_window(win_reg[$urandom_range(0, 3)]),
                     near_window(win_reg[$urandom_range(4, 7)]), cls, $urandom);
  endfunction

  function automatic logic [63:0] random_window(bit narrow);
    logic [31:0] lo, span;
    case ($urandom_range(0, 5))
      0: return WIN_ALL;
      1: return WIN_NONE;
      default: begin
        lo = $urandom;
        span = narrow ? $urandom_range(0, 32'h0100_0000) : $urandom_range(0, 32'h4000_0000);
        return {lo, (lo > ~span) ? 32'hFFFF_FFFF : lo + span};
      end
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is sent and every result has come back.
  task automatic drain();
    while (pending_items.size() > 0 || push || expected_results.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_phase(int count, bit with_hold);
    for (int r = 0; r < 8; r++) write_reg(3'(r), random_window(r < 4));
    idling = 1'b1;
    for (int k = 0; k < count; k++) pending_items.push_back(random_item());
    if (with_hold) hold_req++;
    drain();
  endtask

  initial begin
    foreach (win_reg[i]) win_reg[i] = '0;
    foreach (q_head[i]) begin
      q_head[i] = 0;
      q_fill[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset windows are all [0,0]: address zero is rejected and routes to port one.
    pending_items.push_back(make_item(REQ_STATS, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_FORWARD, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_ARRIVE, 0, 0, 0, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(REQ_ARRIVE, 1, 0, CLASS_UNKNOWN, 0));
    pending_items.push_back(make_item(REQ_ARRIVE, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(3'd6, 0, 0, 0, 0));
    pending_items.push_back(make_item(3'd7, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_FORWARD, 0, 0, 0, 0));
    drain();

    // Fixed windows: each class, each port, broadcast, bad destination, stop and resume.
    write_reg(CFG_REJ_A, {32'h0000_1000, 32'h0000_1FFF});
    write_reg(CFG_REJ_B, WIN_NONE);
    write_reg(CFG_REJ_C, {32'hFFFF_FF00, 32'hFFFF_FFFF});
    write_reg(CFG_REJ_D, {32'h0, 32'h0});
    write_reg(CFG_PORT1, {32'h0, 32'h3FFF_FFFF});
    write_reg(CFG_PORT2, {32'h4000_0000, 32'h7FFF_FFFF});
    write_reg(CFG_PORT3, {32'h8000_0000, 32'hBFFF_FFFF});
    write_reg(CFG_BCAST, {32'hC000_0000, 32'hFFFF_FFFE});
    pending_items.push_back(make_item(REQ_ARRIVE, 32'h10, 32'h8000_0000, 2, 32'h33));
    pending_items.push_back(make_item(REQ_ARRIVE, 32'h20, 32'h4000_0000, 1, 32'h22));
    pending_items.push_back(make_item(REQ_ARRIVE, 32'h30, 32'h3FFF_FFFF, 0, 32'h11));
    pending_items.push_back(make_item(REQ_ARRIVE, 32'h40, 32'hFFFF_FFFE, 0, 32'h44));
    pending_items.push_back(make_item(REQ_ARRIVE, 32'h50, 32'hFFFF_FFFF, 1, 32'h55));
    for (int k = 0; k < 6; k++) pending_items.push_back(make_item(REQ_FORWARD, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STOP, 0, 0, 0, 0));
    for (int k = 0; k < 10; k++)
      pending_items.push_back(make_item(REQ_ARRIVE, 32'h1000 + k, 0, 0, k));
    pending_items.push_back(make_item(REQ_STOP, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_ARRIVE, 32'h60, 0, 0, 0));
    pending_items.push_back(make_item(REQ_FORWARD, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STATS, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_RESET, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STATS, 0, 0, 0, 0));
    drain();

    // Random traffic under several window settings, one with a long output stall.
    random_phase(60, 1'b0);
    random_phase(60, 1'b1);
    for (int r = 0; r < 8; r++) write_reg(3'(r), (r < 4) ? WIN_NONE : WIN_ALL);
    idling = 1'b1;
    for (int k = 0; k < 60; k++) pending_items.push_back(random_item());
    drain();
    random_phase(60, 1'b0);

    // Queue a few packets in every class, then forward until all queues are idle.
    for (int r = 0; r < 4; r++) write_reg(3'(r), WIN_NONE);
    write_reg(CFG_PORT1, WIN_ALL);
    idling = 1'b0;
    pending_items.push_back(make_item(REQ_RESET, 0, 0, 0, 0));
    for (int k = 0; k < 9; k++)
      pending_items.push_back(make_item(REQ_ARRIVE, $urandom, $urandom, 2'(k % 3), k));
    for (int k = 0; k < 11; k++)
      pending_items.push_back(make_item(REQ_FORWARD, 0, 0, 0, 0));
    drain();

    if (errors == 0) begin
      $display("priority_packet_router_core: match");
    end else begin
      $display("priority_packet_router_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("priority_packet_router_core: mismatch");
    $finish;
  end

endmodule
